@@ rtl/dpd_pkg.sv @@
// Shared constants for the delta peak detector: default widths, configuration
// register indexes and result kind codes.
// No dependencies.
package dpd_pkg;

    localparam int SampleWidthDefault = 16;
    localparam int IndexWidthDefault  = 32;

    // Fixed widths of the result index and configuration data fields.
    localparam int OutIndexWidth = 32;
    localparam int DeltaWidth    = 16;
    localparam int CfgIndexWidth = 1;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] CFG_HYST_DELTA = 1'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_START_PEAK = 1'd1;

    // Kinds of confirmed extremes.
    localparam logic KIND_PEAK   = 1'b0;
    localparam logic KIND_VALLEY = 1'b1;

endpackage

@@ rtl/delta_peak_detector.sv @@
// Delta peak detector top level: input register, extreme tracking and
// confirmation logic, and a result register.
// Depends on dpd_pkg.
//
//  Channel   Direction  Handshake           Payload
//  input     in         in_valid/in_stall   sample_value, record_start
//  result    out        out_valid/out_stall extreme_index, extreme_kind
//  config    in         cfg_we              cfg_index, cfg_data
//
// One sample is taken every cycle unless in_stall is high; its result passes
// through the input register, then the result register.
// The tracking state is updated once per sample; it feeds back through its own
// registers and sets the throughput of one per cycle while nothing stalls.
// An asynchronous active-low reset clears the state, the delta to zero and
// selects peak hunting first.
// A stalled result stops the input stage only when the input register also
// holds a sample; otherwise the next sample is still taken.
module delta_peak_detector #(
    parameter int SAMPLE_WIDTH = dpd_pkg::SampleWidthDefault,
    parameter int INDEX_WIDTH  = dpd_pkg::IndexWidthDefault
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_value,
    input  logic                                   record_start,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [dpd_pkg::OutIndexWidth-1:0]      extreme_index,
    output logic                                   extreme_kind,
    input  logic                                   cfg_we,
    input  logic [dpd_pkg::CfgIndexWidth-1:0]      cfg_index,
    input  logic [dpd_pkg::DeltaWidth-1:0]         cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int IW = INDEX_WIDTH;
    localparam int OW = dpd_pkg::OutIndexWidth;
    localparam int DW = dpd_pkg::DeltaWidth;
    // Compare width: holds a sample plus or minus the full delta.
    localparam int CW = ((SW > DW) ? SW : DW) + 2;

    // Configuration registers.
    logic [DW-1:0] hyst_delta_reg;
    logic          start_peak_reg;

    // Input register.
    logic                 s1_valid_reg;
    logic signed [SW-1:0] s1_sample_reg;
    logic                 s1_start_reg;

    // Tracking state.
    logic                 hunting_peak_reg, hunting_peak_next;
    logic signed [SW-1:0] held_max_reg, held_max_next;
    logic [IW-1:0]        held_max_idx_reg, held_max_idx_next;
    logic signed [SW-1:0] held_min_reg, held_min_next;
    logic [IW-1:0]        held_min_idx_reg, held_min_idx_next;
    logic [IW-1:0]        counter_reg, counter_next;

    // Result register.
    logic          out_valid_reg;
    logic [IW-1:0] out_idx_reg, out_idx_next;
    logic          out_kind_reg, out_kind_next;
    logic          res_valid;

    logic proc;
    logic in_xfer;

    // Working values of the update.
    logic signed [SW-1:0] s;
    logic [IW-1:0]        idx;
    logic signed [SW-1:0] mx, mn;
    logic [IW-1:0]        mx_idx, mn_idx;
    logic                 gt_max, lt_min, lt_min2, gt_max2;
    logic signed [CW-1:0] s_ext, mx_ext, mn_ext, d_ext;
    logic                 conf;
    logic [IW+OW-1:0]     idx_wide;

    // The input register drains when the result slot is empty or being taken.
    assign proc     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !proc;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        s   = s1_sample_reg;
        idx = counter_reg;

        s_ext = {{(CW-SW){s[SW-1]}}, s};
        d_ext = {{(CW-DW){1'b0}}, hyst_delta_reg};

        hunting_peak_next = hunting_peak_reg;
        held_max_next     = held_max_reg;
        held_max_idx_next = held_max_idx_reg;
        held_min_next     = held_min_reg;
        held_min_idx_next = held_min_idx_reg;
        counter_next      = counter_reg;
        res_valid         = 1'b0;
        out_idx_next      = held_max_idx_reg;
        out_kind_next     = dpd_pkg::KIND_PEAK;

        mx      = held_max_reg;
        mx_idx  = held_max_idx_reg;
        mn      = held_min_reg;
        mn_idx  = held_min_idx_reg;
        gt_max  = s > held_max_reg;
        lt_min  = s < held_min_reg;
        lt_min2 = 1'b0;
        gt_max2 = 1'b0;
        mx_ext  = '0;
        mn_ext  = '0;
        conf    = 1'b0;

        if (s1_start_reg)
        begin
            hunting_peak_next = start_peak_reg;
            held_max_next     = s;
            held_min_next     = s;
            held_max_idx_next = '0;
            held_min_idx_next = '0;
            counter_next      = {{(IW-1){1'b0}}, 1'b1};
        end
        else
        begin
            counter_next = idx + {{(IW-1){1'b0}}, 1'b1};
            if (hunting_peak_reg)
            begin
                // A new maximum also restarts the minimum at this sample.
                if (gt_max)
                begin
                    mx     = s;
                    mx_idx = idx;
                    mn     = s;
                    mn_idx = idx;
                end
                lt_min2 = s < mn;
                if (lt_min2)
                begin
                    mn     = s;
                    mn_idx = idx;
                end
                mx_ext = {{(CW-SW){mx[SW-1]}}, mx};
                conf   = s_ext < (mx_ext - d_ext);
                held_max_next     = mx;
                held_max_idx_next = mx_idx;
                held_min_next     = mn;
                held_min_idx_next = mn_idx;
                if (conf)
                begin
                    res_valid         = 1'b1;
                    out_idx_next      = mx_idx;
                    out_kind_next     = dpd_pkg::KIND_PEAK;
                    hunting_peak_next = 1'b0;
                    held_max_next     = mn;
                    held_max_idx_next = mn_idx;
                end
            end
            else
            begin
                if (lt_min)
                begin
                    mn     = s;
                    mn_idx = idx;
                    mx     = s;
                    mx_idx = idx;
                end
                gt_max2 = s > mx;
                if (gt_max2)
                begin
                    mx     = s;
                    mx_idx = idx;
                end
                mn_ext = {{(CW-SW){mn[SW-1]}}, mn};
                conf   = s_ext > (mn_ext + d_ext);
                held_max_next     = mx;
                held_max_idx_next = mx_idx;
                held_min_next     = mn;
                held_min_idx_next = mn_idx;
                if (conf)
                begin
                    res_valid         = 1'b1;
                    out_idx_next      = mn_idx;
                    out_kind_next     = dpd_pkg::KIND_VALLEY;
                    hunting_peak_next = 1'b1;
                    held_min_next     = mx;
                    held_min_idx_next = mx_idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_delta_reg <= '0;
            start_peak_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpd_pkg::CFG_HYST_DELTA: hyst_delta_reg <= cfg_data;
                dpd_pkg::CFG_START_PEAK: start_peak_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            hunting_peak_reg <= 1'b1;
            held_max_reg     <= '0;
            held_max_idx_reg <= '0;
            held_min_reg     <= '0;
            held_min_idx_reg <= '0;
            counter_reg      <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (proc)
            begin
                out_valid_reg    <= res_valid;
                hunting_peak_reg <= hunting_peak_next;
                held_max_reg     <= held_max_next;
                held_max_idx_reg <= held_max_idx_next;
                held_min_reg     <= held_min_next;
                held_min_idx_reg <= held_min_idx_next;
                counter_reg      <= counter_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg <= sample_value;
            s1_start_reg  <= record_start;
        end
        if (proc && res_valid)
        begin
            out_idx_reg  <= out_idx_next;
            out_kind_reg <= out_kind_next;
        end
    end

    assign idx_wide      = {{OW{1'b0}}, out_idx_reg};
    assign out_valid     = out_valid_reg;
    assign extreme_index = idx_wide[OW-1:0];
    assign extreme_kind  = out_kind_reg;

    // The input side only stalls when both stages are occupied and blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    // A result only appears when a sample was in the input register.
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !(out_valid_reg && out_stall)) |=> !out_valid_reg)
        else $error("result appeared without a sample");

    // The first sample of a record never confirms an extreme.
    a_record_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && s1_start_reg) |=> !out_valid_reg)
        else $error("result produced by a record start sample");

    // Confirming a peak switches the hunt to a valley, and the reverse.
    a_hunt_alternates: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && res_valid) |=> (hunting_peak_reg == (out_kind_reg == dpd_pkg::KIND_VALLEY)))
        else $error("hunt direction did not follow the confirmed kind");

endmodule
